### rtl/ssuie_pkg.sv
// Shared constants, types and the sequencer program of the set union/intersection core.
`default_nettype none

package ssuie_pkg;

   localparam int unsigned SET_CAPACITY_DEFAULT = 16;
   localparam int unsigned OUT_LIMIT            = 32;
   localparam int unsigned N_W                  = $clog2(OUT_LIMIT + 1);
   localparam int unsigned STEP_W               = 5;

   localparam logic [N_W-1:0] OUT_LIMIT_N = N_W'(OUT_LIMIT);

   // Command codes.
   localparam logic [2:0] CMD_LOAD_A = 3'd0;
   localparam logic [2:0] CMD_LOAD_B = 3'd1;
   localparam logic [2:0] CMD_CLEAR  = 3'd2;
   localparam logic [2:0] CMD_UNION  = 3'd3;
   localparam logic [2:0] CMD_INTER  = 3'd4;
   localparam logic [2:0] CMD_EQUAL  = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_UNION   = 2'd0;
   localparam logic [1:0] KIND_INTER   = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;
   localparam logic [1:0] KIND_EMPTY   = 2'd3;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_OUTER_DONE,
      COND_INNER_DONE,
      COND_MATCH,
      COND_LIMIT,
      COND_COUNTS_DIFFER
   } cond_type;

   typedef struct packed {
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic [1:0]        push_kind;
      logic              outer_b;
      logic              clr_i;
      logic              clr_j;
      logic              inc_i;
      logic              inc_j;
      logic              push;
      logic              push_eq;
      logic              finish;
   } uword_type;

   // Action flags of a control word.
   localparam logic [7:0] F_NONE    = 8'h00;
   localparam logic [7:0] F_OUTER_B = 8'h01;
   localparam logic [7:0] F_CLR_I   = 8'h02;
   localparam logic [7:0] F_CLR_J   = 8'h04;
   localparam logic [7:0] F_INC_I   = 8'h08;
   localparam logic [7:0] F_INC_J   = 8'h10;
   localparam logic [7:0] F_PUSH    = 8'h20;
   localparam logic [7:0] F_PUSH_EQ = 8'h40;
   localparam logic [7:0] F_FINISH  = 8'h80;

   // Program steps.
   localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_UA_TEST   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_UA_EMIT   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_UA_LIMIT  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_UA_LOOP   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_UB_INIT   = 5'd5;
   localparam logic [STEP_W-1:0] STEP_UB_OUTER  = 5'd6;
   localparam logic [STEP_W-1:0] STEP_UB_INNER  = 5'd7;
   localparam logic [STEP_W-1:0] STEP_UB_CMP    = 5'd8;
   localparam logic [STEP_W-1:0] STEP_UB_ILOOP  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_UB_EMIT   = 5'd10;
   localparam logic [STEP_W-1:0] STEP_UB_NEXT   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_UB_OLOOP  = 5'd12;
   localparam logic [STEP_W-1:0] STEP_IN_OUTER  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_IN_INNER  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_IN_CMP    = 5'd15;
   localparam logic [STEP_W-1:0] STEP_IN_ILOOP  = 5'd16;
   localparam logic [STEP_W-1:0] STEP_IN_EMIT   = 5'd17;
   localparam logic [STEP_W-1:0] STEP_IN_NEXT   = 5'd18;
   localparam logic [STEP_W-1:0] STEP_IN_OLOOP  = 5'd19;
   localparam logic [STEP_W-1:0] STEP_EQ_START  = 5'd20;
   localparam logic [STEP_W-1:0] STEP_EQ_OUTER  = 5'd21;
   localparam logic [STEP_W-1:0] STEP_EQ_INNER  = 5'd22;
   localparam logic [STEP_W-1:0] STEP_EQ_CMP    = 5'd23;
   localparam logic [STEP_W-1:0] STEP_EQ_ILOOP  = 5'd24;
   localparam logic [STEP_W-1:0] STEP_EQ_NEXT   = 5'd25;
   localparam logic [STEP_W-1:0] STEP_EQ_TRUE   = 5'd26;
   localparam logic [STEP_W-1:0] STEP_EQ_FALSE  = 5'd27;
   localparam logic [STEP_W-1:0] STEP_FIN       = 5'd28;

   function automatic uword_type mk(cond_type c, logic [STEP_W-1:0] t, logic [1:0] k,
                                    logic [7:0] f);
      uword_type w;
      w.cond      = c;
      w.target    = t;
      w.push_kind = k;
      w.outer_b   = |(f & F_OUTER_B);
      w.clr_i     = |(f & F_CLR_I);
      w.clr_j     = |(f & F_CLR_J);
      w.inc_i     = |(f & F_INC_I);
      w.inc_j     = |(f & F_INC_J);
      w.push      = |(f & F_PUSH);
      w.push_eq   = |(f & F_PUSH_EQ);
      w.finish    = |(f & F_FINISH);
      return w;
   endfunction

   // The program store. The outer index walks the outer set, the inner index the other one.
   function automatic uword_type rom_word(logic [STEP_W-1:0] step);
      uword_type w;
      w = mk(COND_ALWAYS, STEP_IDLE, KIND_UNION, F_NONE);
      case (step)
         STEP_UA_TEST:  w = mk(COND_OUTER_DONE, STEP_UB_INIT, KIND_UNION, F_NONE);
         STEP_UA_EMIT:  w = mk(COND_NEXT, STEP_IDLE, KIND_UNION, F_PUSH | F_INC_I);
         STEP_UA_LIMIT: w = mk(COND_LIMIT, STEP_FIN, KIND_UNION, F_NONE);
         STEP_UA_LOOP:  w = mk(COND_ALWAYS, STEP_UA_TEST, KIND_UNION, F_NONE);
         STEP_UB_INIT:  w = mk(COND_NEXT, STEP_IDLE, KIND_UNION, F_CLR_I);
         STEP_UB_OUTER: w = mk(COND_OUTER_DONE, STEP_FIN, KIND_UNION, F_OUTER_B | F_CLR_J);
         STEP_UB_INNER: w = mk(COND_INNER_DONE, STEP_UB_EMIT, KIND_UNION, F_OUTER_B);
         STEP_UB_CMP:   w = mk(COND_MATCH, STEP_UB_NEXT, KIND_UNION, F_OUTER_B | F_INC_J);
         STEP_UB_ILOOP: w = mk(COND_ALWAYS, STEP_UB_INNER, KIND_UNION, F_OUTER_B);
         STEP_UB_EMIT:  w = mk(COND_NEXT, STEP_IDLE, KIND_UNION, F_OUTER_B | F_PUSH);
         STEP_UB_NEXT:  w = mk(COND_LIMIT, STEP_FIN, KIND_UNION, F_OUTER_B | F_INC_I);
         STEP_UB_OLOOP: w = mk(COND_ALWAYS, STEP_UB_OUTER, KIND_UNION, F_OUTER_B);
         STEP_IN_OUTER: w = mk(COND_OUTER_DONE, STEP_FIN, KIND_INTER, F_CLR_J);
         STEP_IN_INNER: w = mk(COND_INNER_DONE, STEP_IN_NEXT, KIND_INTER, F_NONE);
         STEP_IN_CMP:   w = mk(COND_MATCH, STEP_IN_EMIT, KIND_INTER, F_INC_J);
         STEP_IN_ILOOP: w = mk(COND_ALWAYS, STEP_IN_INNER, KIND_INTER, F_NONE);
         STEP_IN_EMIT:  w = mk(COND_NEXT, STEP_IDLE, KIND_INTER, F_PUSH);
         STEP_IN_NEXT:  w = mk(COND_LIMIT, STEP_FIN, KIND_INTER, F_INC_I);
         STEP_IN_OLOOP: w = mk(COND_ALWAYS, STEP_IN_OUTER, KIND_INTER, F_NONE);
         STEP_EQ_START: w = mk(COND_COUNTS_DIFFER, STEP_EQ_FALSE, KIND_VERDICT, F_NONE);
         STEP_EQ_OUTER: w = mk(COND_OUTER_DONE, STEP_EQ_TRUE, KIND_VERDICT, F_CLR_J);
         STEP_EQ_INNER: w = mk(COND_INNER_DONE, STEP_EQ_FALSE, KIND_VERDICT, F_NONE);
         STEP_EQ_CMP:   w = mk(COND_MATCH, STEP_EQ_NEXT, KIND_VERDICT, F_INC_J);
         STEP_EQ_ILOOP: w = mk(COND_ALWAYS, STEP_EQ_INNER, KIND_VERDICT, F_NONE);
         STEP_EQ_NEXT:  w = mk(COND_ALWAYS, STEP_EQ_OUTER, KIND_VERDICT, F_INC_I);
         STEP_EQ_TRUE:  w = mk(COND_ALWAYS, STEP_FIN, KIND_VERDICT, F_PUSH | F_PUSH_EQ);
         STEP_EQ_FALSE: w = mk(COND_NEXT, STEP_IDLE, KIND_VERDICT, F_PUSH);
         STEP_FIN:      w = mk(COND_ALWAYS, STEP_IDLE, KIND_EMPTY, F_FINISH);
         default:       w = mk(COND_ALWAYS, STEP_IDLE, KIND_UNION, F_NONE);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### rtl/ssuie_ifs.sv
// Request and response channel interfaces of the set union/intersection core.
`default_nettype none

interface ssuie_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface ssuie_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] element;
   logic               is_last;
   logic               sets_equal;
   logic               load_dropped;

   modport source (output valid, output kind, output element, output is_last,
                   output sets_equal, output load_dropped, input ready);
   modport sink   (input valid, input kind, input element, input is_last,
                   input sets_equal, input load_dropped, output ready);
endinterface

`default_nettype wire

### rtl/ssuie_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module ssuie_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/small_set_union_intersection_equality_core.sv
// Load, clear: the next request is taken in the following cycle.
// Union, intersection and equality are run by the sequencer program, whose nested compare
// loop walks the two set RAMs.
// Results leave one behind the sequencer through a hold stage and an output register.
// Synchronous reset empties both sets and clears the drop flag; no clearing pass.
`default_nettype none

module small_set_union_intersection_equality_core #(
   parameter int unsigned SET_CAPACITY = ssuie_pkg::SET_CAPACITY_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   ssuie_req_if.sink   req_if,
   ssuie_rsp_if.source rsp_if
);

   localparam int unsigned CNT_W  = $clog2(SET_CAPACITY + 1);
   localparam int unsigned ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAPACITY);

   logic [ssuie_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0]             cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]             i_ff, i_in, j_ff, j_in;
   logic [ssuie_pkg::N_W-1:0]    n_ff, n_in;
   logic                         dropped_ff, dropped_in;

   logic                         hold_valid_ff, hold_valid_in;
   logic [1:0]                   hold_kind_ff, hold_kind_in;
   logic signed [31:0]           hold_elem_ff, hold_elem_in;
   logic                         hold_eq_ff, hold_eq_in;

   logic                         out_valid_ff, out_valid_in;
   logic [1:0]                   out_kind_ff, out_kind_in;
   logic signed [31:0]           out_elem_ff, out_elem_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_eq_ff, out_eq_in;
   logic                         out_dropped_ff, out_dropped_in;

   ssuie_pkg::uword_type         uw;
   logic                         running, accept, stall, cond_true, out_free, out_load, match;
   logic [CNT_W-1:0]             outer_cnt, inner_cnt, a_rd_idx, b_rd_idx;
   logic signed [31:0]           outer_data;

   logic                         a_we, b_we;
   logic [ADDR_W-1:0]            a_addr, b_addr;
   logic [31:0]                  a_rdata, b_rdata;

   ssuie_ram #(.WIDTH(32), .DEPTH(SET_CAPACITY), .ADDR_W(ADDR_W)) u_ram_a (
      .clock (clock),
      .we    (a_we),
      .addr  (a_addr),
      .wdata (req_if.value),
      .rdata (a_rdata)
   );

   ssuie_ram #(.WIDTH(32), .DEPTH(SET_CAPACITY), .ADDR_W(ADDR_W)) u_ram_b (
      .clock (clock),
      .we    (b_we),
      .addr  (b_addr),
      .wdata (req_if.value),
      .rdata (b_rdata)
   );

   always_comb begin
      uw = ssuie_pkg::rom_word(pc_ff);
   end

   assign running  = (pc_ff != ssuie_pkg::STEP_IDLE);
   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !out_valid_ff || rsp_if.ready;
   // A push only needs the output register when a result is already held.
   assign stall    = running && ((uw.push && hold_valid_ff) || uw.finish) && !out_free;
   assign out_load = running && !stall && ((uw.push && hold_valid_ff) || uw.finish);

   assign outer_cnt  = uw.outer_b ? cnt_b_ff : cnt_a_ff;
   assign inner_cnt  = uw.outer_b ? cnt_a_ff : cnt_b_ff;
   assign a_rd_idx   = uw.outer_b ? j_ff : i_ff;
   assign b_rd_idx   = uw.outer_b ? i_ff : j_ff;
   assign outer_data = uw.outer_b ? $signed(b_rdata) : $signed(a_rdata);
   assign match      = (a_rdata == b_rdata);

   assign a_we   = accept && (req_if.command == ssuie_pkg::CMD_LOAD_A) && (cnt_a_ff < CAP);
   assign b_we   = accept && (req_if.command == ssuie_pkg::CMD_LOAD_B) && (cnt_b_ff < CAP);
   assign a_addr = a_we ? cnt_a_ff[ADDR_W-1:0] : a_rd_idx[ADDR_W-1:0];
   assign b_addr = b_we ? cnt_b_ff[ADDR_W-1:0] : b_rd_idx[ADDR_W-1:0];

   always_comb begin
      case (uw.cond)
         ssuie_pkg::COND_NEXT:          cond_true = 1'b0;
         ssuie_pkg::COND_ALWAYS:        cond_true = 1'b1;
         ssuie_pkg::COND_OUTER_DONE:    cond_true = (i_ff >= outer_cnt);
         ssuie_pkg::COND_INNER_DONE:    cond_true = (j_ff >= inner_cnt);
         ssuie_pkg::COND_MATCH:         cond_true = match;
         ssuie_pkg::COND_LIMIT:         cond_true = (n_ff == ssuie_pkg::OUT_LIMIT_N);
         ssuie_pkg::COND_COUNTS_DIFFER: cond_true = (cnt_a_ff != cnt_b_ff);
         default:                       cond_true = 1'b1;
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      dropped_in    = dropped_ff;
      hold_valid_in = hold_valid_ff;
      hold_kind_in  = hold_kind_ff;
      hold_elem_in  = hold_elem_ff;
      hold_eq_in    = hold_eq_ff;

      if (accept) begin
         i_in = '0;
         j_in = '0;
         n_in = '0;
         case (req_if.command)
            ssuie_pkg::CMD_LOAD_A: begin
               if (cnt_a_ff < CAP) begin
                  cnt_a_in = cnt_a_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            ssuie_pkg::CMD_LOAD_B: begin
               if (cnt_b_ff < CAP) begin
                  cnt_b_in = cnt_b_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            ssuie_pkg::CMD_CLEAR: begin
               cnt_a_in = '0;
               cnt_b_in = '0;
            end
            ssuie_pkg::CMD_UNION: pc_in = ssuie_pkg::STEP_UA_TEST;
            ssuie_pkg::CMD_INTER: pc_in = ssuie_pkg::STEP_IN_OUTER;
            ssuie_pkg::CMD_EQUAL: pc_in = ssuie_pkg::STEP_EQ_START;
            default: ;
         endcase
      end else if (running && !stall) begin
         pc_in = cond_true ? uw.target : pc_ff + ssuie_pkg::STEP_W'(1);
         if (uw.clr_i) begin
            i_in = '0;
         end
         if (uw.inc_i) begin
            i_in = i_ff + CNT_W'(1);
         end
         if (uw.clr_j) begin
            j_in = '0;
         end
         if (uw.inc_j) begin
            j_in = j_ff + CNT_W'(1);
         end
         // The newest result is kept back so that is_last can be set when the program ends.
         if (uw.push) begin
            hold_valid_in = 1'b1;
            hold_kind_in  = uw.push_kind;
            hold_elem_in  = (uw.push_kind == ssuie_pkg::KIND_VERDICT) ? 32'sd0 : outer_data;
            hold_eq_in    = uw.push_eq;
            n_in          = n_ff + ssuie_pkg::N_W'(1);
         end
         if (uw.finish) begin
            hold_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_kind_in    = out_kind_ff;
      out_elem_in    = out_elem_ff;
      out_last_in    = out_last_ff;
      out_eq_in      = out_eq_ff;
      out_dropped_in = out_dropped_ff;

      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_dropped_in = dropped_ff;
         if (hold_valid_ff) begin
            out_kind_in = hold_kind_ff;
            out_elem_in = hold_elem_ff;
            out_eq_in   = hold_eq_ff;
            out_last_in = uw.finish;
         end else begin
            // Nothing was produced: the transaction is a lone empty marker.
            out_kind_in = ssuie_pkg::KIND_EMPTY;
            out_elem_in = 32'sd0;
            out_eq_in   = 1'b0;
            out_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= ssuie_pkg::STEP_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         dropped_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         dropped_ff    <= dropped_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff           <= i_in;
      j_ff           <= j_in;
      n_ff           <= n_in;
      hold_kind_ff   <= hold_kind_in;
      hold_elem_ff   <= hold_elem_in;
      hold_eq_ff     <= hold_eq_in;
      out_kind_ff    <= out_kind_in;
      out_elem_ff    <= out_elem_in;
      out_last_ff    <= out_last_in;
      out_eq_ff      <= out_eq_in;
      out_dropped_ff <= out_dropped_in;
   end

   assign req_if.ready        = !running;
   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.kind         = out_kind_ff;
   assign rsp_if.element      = out_elem_ff;
   assign rsp_if.is_last      = out_last_ff;
   assign rsp_if.sets_equal   = out_eq_ff;
   assign rsp_if.load_dropped = out_dropped_ff;

endmodule

`default_nettype wire

### verif/small_set_union_intersection_equality_core_tb.sv
// Self-checking testbench of the set union, intersection and equality core.
`timescale 1ns / 100ps

module small_set_union_intersection_equality_core_tb;

   localparam int unsigned CAPACITY    = ssuie_pkg::SET_CAPACITY_DEFAULT;
   localparam int unsigned ITEM_TARGET = 380;
   localparam int unsigned CYCLE_LIMIT = 2000000;
   localparam int unsigned MAX_REPORTS = 60;

   // The two command codes that the core ignores.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] element;
      logic        is_last;
      logic        sets_equal;
      logic        load_dropped;
   } set_result_type;

   class set_scoreboard_type;
      logic [31:0]    members_a[CAPACITY];
      logic [31:0]    members_b[CAPACITY];
      int unsigned    size_a;
      int unsigned    size_b;
      bit             drop_sticky;
      set_result_type results_due[$];
      set_result_type stream[$];
      int unsigned    errors;
      int unsigned    checked;

      function new();
         size_a      = 0;
         size_b      = 0;
         drop_sticky = 1'b0;
         errors      = 0;
         checked     = 0;
      endfunction

      function bit a_holds(logic [31:0] v);
         for (int j = 0; j < size_a; j++)
            if (members_a[j] === v) return 1'b1;
         return 1'b0;
      endfunction

      function bit b_holds(logic [31:0] v);
         for (int j = 0; j < size_b; j++)
            if (members_b[j] === v) return 1'b1;
         return 1'b0;
      endfunction

      function void emit_one(logic [1:0] kind, logic [31:0] elem, bit eq);
         set_result_type r;
         if (stream.size() >= ssuie_pkg::OUT_LIMIT) return;
         r.kind         = kind;
         r.element      = elem;
         r.is_last      = 1'b0;
         r.sets_equal   = eq;
         r.load_dropped = drop_sticky;
         stream.push_back(r);
      endfunction

      // Updates the set contents for one accepted transaction and queues its results.
      function void predict_command(logic [2:0] cmd, logic [31:0] val);
         bit             eq;
         set_result_type r;
         stream.delete();
         case (cmd)
            ssuie_pkg::CMD_LOAD_A: begin
               if (size_a < CAPACITY) begin
                  members_a[size_a] = val;
                  size_a++;
               end else begin
                  drop_sticky = 1'b1;
               end
               return;
            end
            ssuie_pkg::CMD_LOAD_B: begin
               if (size_b < CAPACITY) begin
                  members_b[size_b] = val;
                  size_b++;
               end else begin
                  drop_sticky = 1'b1;
               end
               return;
            end
            ssuie_pkg::CMD_CLEAR: begin
               size_a = 0;
               size_b = 0;
               return;
            end
            ssuie_pkg::CMD_UNION: begin
               for (int i = 0; i < size_a; i++)
                  emit_one(ssuie_pkg::KIND_UNION, members_a[i], 1'b0);
               for (int i = 0; i < size_b; i++)
                  if (!a_holds(members_b[i]))
                     emit_one(ssuie_pkg::KIND_UNION, members_b[i], 1'b0);
            end
            ssuie_pkg::CMD_INTER: begin
               for (int i = 0; i < size_a; i++)
                  if (b_holds(members_a[i]))
                     emit_one(ssuie_pkg::KIND_INTER, members_a[i], 1'b0);
            end
            ssuie_pkg::CMD_EQUAL: begin
               eq = (size_a == size_b);
               for (int i = 0; eq && i < size_a; i++)
                  if (!b_holds(members_a[i])) eq = 1'b0;
               emit_one(ssuie_pkg::KIND_VERDICT, 32'd0, eq);
            end
            default: return;
         endcase
         if (stream.size() == 0) emit_one(ssuie_pkg::KIND_EMPTY, 32'd0, 1'b0);
         r = stream.pop_back();
         r.is_last = 1'b1;
         stream.push_back(r);
         foreach (stream[k]) results_due.push_back(stream[k]);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, what);
      endtask

      task check_result(set_result_type got);
         set_result_type want;
         checked++;
         if (results_due.size() == 0) begin
            report($sformatf("unexpected result kind %0d element %h", got.kind, got.element));
            return;
         end
         want = results_due.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.element !== want.element)
            report($sformatf("element %h, expected %h", got.element, want.element));
         if (got.is_last !== want.is_last)
            report($sformatf("is_last %b, expected %b", got.is_last, want.is_last));
         if (got.sets_equal !== want.sets_equal)
            report($sformatf("sets_equal %b, expected %b", got.sets_equal, want.sets_equal));
         if (got.load_dropped !== want.load_dropped)
            report($sformatf("load_dropped %b, expected %b", got.load_dropped,
                             want.load_dropped));
      endtask

      task flush_missing();
         set_result_type want;
         while (results_due.size() != 0) begin
            want = results_due.pop_front();
            report($sformatf("missing result kind %0d element %h", want.kind, want.element));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ssuie_req_if req_ch ();
   ssuie_rsp_if rsp_ch ();

   small_set_union_intersection_equality_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   set_scoreboard_type sb = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left  = 0;
   int unsigned items_done  = 0;
   int unsigned cmd_tally[8];
   logic [31:0] value_pool[6];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver back-pressure: a mode is held for a random stretch, then another is drawn.
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      int unsigned phase;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (phase % 7 < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      set_result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.kind         = rsp_ch.kind;
         got.element      = rsp_ch.element;
         got.is_last      = rsp_ch.is_last;
         got.sets_equal   = rsp_ch.sets_equal;
         got.load_dropped = rsp_ch.load_dropped;
         sb.check_result(got);
      end
   end

   // Offers one transaction and returns at the edge where it is taken.
   task automatic send_request(input logic [2:0] cmd, input logic [31:0] val);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.value   <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.predict_command(cmd, val);
      burst_left--;
      cmd_tally[cmd]++;
      items_done++;
   endtask

   task automatic send_query();
      case ($urandom_range(0, 2))
         0:       send_request(ssuie_pkg::CMD_UNION, $urandom);
         1:       send_request(ssuie_pkg::CMD_INTER, $urandom);
         default: send_request(ssuie_pkg::CMD_EQUAL, $urandom);
      endcase
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 11) == 0)
         send_request($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom);
   endtask

   function automatic logic [31:0] pick_value(int unsigned pool_share);
      if ($urandom_range(1, 4) <= pool_share) return value_pool[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   function automatic int unsigned pick_size();
      if ($urandom_range(0, 11) == 0) return CAPACITY + $urandom_range(1, 3);
      if ($urandom_range(0, 5) == 0) return $urandom_range(0, CAPACITY);
      return $urandom_range(0, 5);
   endfunction

   // One set-up of A and B followed by queries; mostly well formed, with noise and
   // overfull or interrupted loads mixed in.
   task automatic run_random_sequence();
      logic [31:0] vals_a[$];
      logic [31:0] vals_b[$];
      logic [31:0] tmp;
      int unsigned n_a;
      int unsigned n_b;
      int unsigned pool_share;
      int unsigned j;
      for (int k = 0; k < 6; k++) begin
         case ($urandom_range(0, 7))
            0:       value_pool[k] = 32'h8000_0000;
            1:       value_pool[k] = 32'h7fff_ffff;
            2:       value_pool[k] = 32'hffff_ffff;
            3:       value_pool[k] = 32'h0000_0000;
            default: value_pool[k] = $urandom;
         endcase
      end
      if ($urandom_range(0, 4) != 0) send_request(ssuie_pkg::CMD_CLEAR, $urandom);
      pool_share = $urandom_range(0, 4);
      n_a = pick_size();
      for (int k = 0; k < n_a; k++) vals_a.push_back(pick_value(pool_share));
      if ($urandom_range(0, 2) == 0) begin
         // B as a reordering of A, sometimes with one element changed.
         vals_b = vals_a;
         for (int k = vals_b.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = vals_b[k];
            vals_b[k] = vals_b[j];
            vals_b[j] = tmp;
         end
         if (vals_b.size() > 0 && $urandom_range(0, 3) == 0)
            vals_b[$urandom_range(0, vals_b.size() - 1)] = pick_value(pool_share);
      end else begin
         n_b = pick_size();
         for (int k = 0; k < n_b; k++) vals_b.push_back(pick_value(pool_share));
      end
      while (vals_a.size() != 0 || vals_b.size() != 0) begin
         if (vals_b.size() == 0 || (vals_a.size() != 0 && $urandom_range(0, 1) == 1))
            send_request(ssuie_pkg::CMD_LOAD_A, vals_a.pop_front());
         else
            send_request(ssuie_pkg::CMD_LOAD_B, vals_b.pop_front());
         maybe_noise();
         if ($urandom_range(0, 19) == 0) send_query();
      end
      repeat ($urandom_range(1, 3)) begin
         send_query();
         maybe_noise();
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.command = ssuie_pkg::CMD_CLEAR;
      req_ch.value   = 32'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty sets, field extremes, duplicates, ignored codes and clear.
      send_request(ssuie_pkg::CMD_UNION, 32'd0);
      send_request(ssuie_pkg::CMD_INTER, 32'hffff_ffff);
      send_request(ssuie_pkg::CMD_EQUAL, 32'd0);
      send_request(ssuie_pkg::CMD_LOAD_A, 32'h8000_0000);
      send_request(ssuie_pkg::CMD_LOAD_A, 32'h7fff_ffff);
      send_request(ssuie_pkg::CMD_LOAD_A, 32'h0000_0000);
      send_request(ssuie_pkg::CMD_LOAD_B, 32'h7fff_ffff);
      send_request(ssuie_pkg::CMD_LOAD_B, 32'hffff_ffff);
      send_request(ssuie_pkg::CMD_LOAD_B, 32'h7fff_ffff);
      send_request(ssuie_pkg::CMD_UNION, 32'hffff_ffff);
      send_request(ssuie_pkg::CMD_INTER, 32'd0);
      send_request(ssuie_pkg::CMD_EQUAL, 32'h8000_0000);
      send_request(CMD_SPARE_6, 32'hffff_ffff);
      send_request(CMD_SPARE_7, 32'h0000_0000);
      send_request(ssuie_pkg::CMD_UNION, 32'd0);
      send_request(ssuie_pkg::CMD_CLEAR, 32'h5a5a_5a5a);
      send_request(ssuie_pkg::CMD_INTER, 32'd0);
      send_request(ssuie_pkg::CMD_UNION, 32'd0);
      send_request(ssuie_pkg::CMD_LOAD_A, 32'h0000_0005);
      send_request(ssuie_pkg::CMD_LOAD_B, 32'h0000_0005);
      send_request(ssuie_pkg::CMD_EQUAL, 32'd0);
      send_request(ssuie_pkg::CMD_INTER, 32'd0);

      while (items_done < ITEM_TARGET) run_random_sequence();

      req_ch.valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      sb.flush_missing();

      $display("Covered %0d loads into A, %0d into B, %0d clears, %0d unions,",
               cmd_tally[ssuie_pkg::CMD_LOAD_A], cmd_tally[ssuie_pkg::CMD_LOAD_B],
               cmd_tally[ssuie_pkg::CMD_CLEAR], cmd_tally[ssuie_pkg::CMD_UNION]);
      $display("%0d intersections, %0d equality checks, %0d ignored codes;",
               cmd_tally[ssuie_pkg::CMD_INTER], cmd_tally[ssuie_pkg::CMD_EQUAL],
               cmd_tally[CMD_SPARE_6] + cmd_tally[CMD_SPARE_7]);
      $display("%0d results checked in %0d cycles.", sb.checked, cycle_count);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### files.f
rtl/ssuie_pkg.sv
rtl/ssuie_ifs.sv
rtl/ssuie_ram.sv
rtl/small_set_union_intersection_equality_core.sv
verif/small_set_union_intersection_equality_core_tb.sv
